FILE: rtl/bus_pkg.sv
package bus_pkg;

  // Default sizing of the set.
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int ACT_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;

  // Action codes. Any other code behaves as a membership query.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHIFT,
    S_REPORT
  } state_t;

endpackage

FILE: rtl/bus_in_if.sv
interface bus_in_if import bus_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [KEY_IN_W-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

FILE: rtl/bus_out_if.sv
interface bus_out_if import bus_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output found, output occupancy, input ready);
  modport sink   (input valid, input status, input found, input occupancy, output ready);
endinterface

FILE: rtl/bus_store.sv
module bus_store import bus_pkg::*; #(
  parameter int DEPTH  = CAPACITY_DEF,
  parameter int WIDTH  = KEY_WIDTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bounded_unique_set.sv
// A transaction is accepted, scanned for its key, executed, compacted on a removal that
// leaves entries after the removed one, and then reported.
// One transaction is worked on at a time; the single read port of the key store sets the pace.
// Reset empties the set by clearing the fill count; stored keys are not cleared.
module bounded_unique_set import bus_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  bus_in_if.sink    in_ch,
  bus_out_if.source out_ch
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t               state_r, state_nxt;
  logic [ACT_W-1:0]     act_r, act_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  status_t              status_r, status_nxt;

  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_found_r;
  logic [OCC_W-1:0]     out_occ_r;
  logic                 out_load;

  logic [KEY_WIDTH-1:0] key_in;
  logic [OCC_W-1:0]     occ_now;
  logic [CNT_W-1:0]     pos_next_ext;
  logic                 hit;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [KEY_WIDTH-1:0] rd_data;

  // Keys are held on their low KEY_WIDTH bits.
  generate
    if (KEY_WIDTH <= KEY_IN_W) begin : g_key_trunc
      assign key_in = in_ch.key[KEY_WIDTH-1:0];
    end else begin : g_key_ext
      assign key_in = {{(KEY_WIDTH - KEY_IN_W){1'b0}}, in_ch.key};
    end
  endgenerate

  // The reported occupancy is the low bits of the count.
  generate
    if (CNT_W >= OCC_W) begin : g_occ_trunc
      assign occ_now = count_r[OCC_W-1:0];
    end else begin : g_occ_ext
      assign occ_now = {{(OCC_W - CNT_W){1'b0}}, count_r};
    end
  endgenerate

  assign pos_next_ext = CNT_W'(pos_r) + CNT_W'(1);
  assign hit          = pend_r && (rd_data == key_r);

  // Key store.
  bus_store #(
    .DEPTH  (CAPACITY),
    .WIDTH  (KEY_WIDTH),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
  end

  // Sequencer: scan for the key, apply the action, compact on removal.
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = pend_idx_r - IDX_W'(1);
    mem_wdata    = rd_data;
    mem_raddr    = ptr_r[IDX_W-1:0];
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = in_ch.action;
          key_nxt   = key_in;
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      // One read is issued per cycle; its data is compared in the cycle after.
      S_SCAN: begin
        priority if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = pend_idx_r;
          state_nxt = S_EXEC;
        end else if (ptr_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt      = ptr_r + CNT_W'(1);
        end else begin
          state_nxt = S_EXEC;
        end
      end

      // A query and the spare code change nothing.
      S_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_REPORT;
        if (act_r == ACT_ADD) begin
          priority if (count_r == CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else if (found_r) begin
            status_nxt = ST_DUP;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IDX_W-1:0];
            mem_wdata = key_r;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (act_r == ACT_REMOVE) begin
          priority if (!found_r) begin
            status_nxt = ST_NOTFOUND;
          end else if (pos_next_ext < count_r) begin
            ptr_nxt   = pos_next_ext;
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end

      // Each entry after the removed one is read and written one place lower.
      S_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (ptr_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt      = ptr_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_REPORT;
        end
      end

      S_REPORT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_occ_r    <= occ_now;
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.occupancy = out_occ_r;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // The store is never written while it is being searched.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("store written during scan");

  // A new result appears only out of the report step.
  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_REPORT))
    else $error("result loaded outside report step");

  // The count changes only when an action is applied or compaction ends.
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |->
      ($past(state_r) == S_EXEC || $past(state_r) == S_SHIFT))
    else $error("fill count changed outside execute or shift");

endmodule

FILE: tb/sv/bounded_unique_set_tb.sv
`timescale 1ns / 1ps

module bounded_unique_set_tb;
  import bus_pkg::*;

  // The spare action code behaves as a membership query.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int POOL_N = 24;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [KEY_IN_W-1:0] key;
    logic                drain;
  } set_cmd_t;

  typedef struct packed {
    status_t          status;
    logic             found;
    logic [OCC_W-1:0] occupancy;
  } set_reply_t;

  logic clk;
  logic rst_n;

  bus_in_if  in_bus ();
  bus_out_if out_bus ();

  bounded_unique_set u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Commands waiting to be sent and replies waiting to arrive.
  set_cmd_t   cmd_q[$];
  set_reply_t set_reply_q[$];

  // Shadow copy of the stored keys in insertion order.
  logic [KEY_WIDTH_DEF-1:0] shadow_keys [CAPACITY_DEF];
  int                       shadow_count;

  logic [KEY_IN_W-1:0] key_pool [POOL_N];

  int accepted_cnt;
  int results_seen;
  int fail_count;
  int burst_left;
  int gap_left;
  int hold_left;
  logic hold_done;
  int seg_left;
  int rx_mode;
  logic [7:0] stall_pat;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Applies one transaction to the shadow set and returns the reply it must produce.
  function automatic set_reply_t shadow_apply(logic [ACT_W-1:0] action,
                                              logic [KEY_IN_W-1:0] key);
    set_reply_t r;
    logic [KEY_WIDTH_DEF-1:0] k;
    int pos;
    logic hit;
    k   = key[KEY_WIDTH_DEF-1:0];
    pos = shadow_count;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_keys[i] == k) pos = i;
    end
    hit = (pos < shadow_count);
    r.status = ST_OK;
    if (action == ACT_ADD) begin
      // A full set rejects the add before the duplicate test.
      if (shadow_count >= CAPACITY_DEF) begin
        r.status = ST_FULL;
      end else if (hit) begin
        r.status = ST_DUP;
      end else begin
        shadow_keys[shadow_count] = k;
        shadow_count++;
      end
    end else if (action == ACT_REMOVE) begin
      if (!hit) begin
        r.status = ST_NOTFOUND;
      end else begin
        for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
      end
    end
    r.found     = hit;
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic push_cmd(logic [ACT_W-1:0] action, logic [KEY_IN_W-1:0] key,
                          logic drain = 1'b0);
    set_cmd_t c;
    c.action = action;
    c.key    = key;
    c.drain  = drain;
    cmd_q.push_back(c);
  endtask

  // Driver: offers queued commands in bursts and predicts each accepted one.
  always @(posedge clk) begin
    set_reply_t want;
    set_cmd_t   c;
    logic       took;
    logic       got;
    logic       drained;
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      in_bus.action <= ACT_QUERY;
      in_bus.key    <= '0;
      accepted_cnt  <= 0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      took = in_bus.valid && in_bus.ready;
      got  = out_bus.valid && out_bus.ready;
      if (took) begin
        want = shadow_apply(in_bus.action, in_bus.key);
        set_reply_q.push_back(want);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        drained = (accepted_cnt + took) == (results_seen + got);
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (cmd_q.size() == 0 || (cmd_q[0].drain && !drained)) begin
          in_bus.valid <= 1'b0;
        end else begin
          c = cmd_q.pop_front();
          in_bus.valid  <= 1'b1;
          in_bus.action <= c.action;
          in_bus.key    <= c.key;
          // Close the burst and schedule the gap before the next one.
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: changes its stall pattern every segment and holds off once for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
      seg_left      <= 0;
      rx_mode       <= 0;
      stall_pat     <= 8'b1011_0010;
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[7:1]};
      if (seg_left == 0) begin
        seg_left <= $urandom_range(20, 120);
        rx_mode  <= $urandom_range(0, 3);
      end else begin
        seg_left <= seg_left - 1;
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 300) begin
        hold_left     <= HOLD_CYCLES;
        hold_done     <= 1'b1;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            out_bus.ready <= 1'b1;
          end
          1: begin
            out_bus.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_bus.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_bus.ready <= stall_pat[0];
          end
        endcase
      end
    end
  end

  // Monitor: compares every result transaction with the oldest expected reply.
  always @(posedge clk) begin
    set_reply_t want;
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      results_seen <= results_seen + 1;
      if (set_reply_q.size() == 0) begin
        $error("result transaction with no expected reply");
        fail_count++;
      end else begin
        want = set_reply_q.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_bus.status);
          fail_count++;
        end
        if (out_bus.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_bus.found);
          fail_count++;
        end
        if (out_bus.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, out_bus.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int bias;
    int roll;
    logic [ACT_W-1:0] act;
    logic [KEY_IN_W-1:0] k;
    rst_n         = 1'b0;
    fail_count    = 0;
    shadow_count  = 0;

    key_pool[0] = 32'hAAAA_AAAA;
    key_pool[1] = 32'h5555_5555;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

    // Directed part: empty set, extreme keys, duplicates, spare code, full set.
    push_cmd(ACT_QUERY, 32'h0000_0000);
    push_cmd(ACT_REMOVE, 32'h0000_0005);
    push_cmd(ACT_ADD, 32'h0000_0000);
    push_cmd(ACT_ADD, 32'hFFFF_FFFF);
    push_cmd(ACT_ADD, 32'h0000_0000);
    push_cmd(ACT_QUERY, 32'hFFFF_FFFF);
    push_cmd(ACT_SPARE, 32'hFFFF_FFFF);
    push_cmd(ACT_SPARE, 32'h1234_5678);
    push_cmd(ACT_REMOVE, 32'h0000_0000, 1'b1);
    push_cmd(ACT_QUERY, 32'h0000_0000);
    for (int i = 0; i < 15; i++) push_cmd(ACT_ADD, key_pool[i]);
    push_cmd(ACT_ADD, 32'hFFFF_FFFF);
    push_cmd(ACT_ADD, 32'h0000_0000);
    push_cmd(ACT_REMOVE, key_pool[7]);
    push_cmd(ACT_REMOVE, key_pool[14]);
    push_cmd(ACT_REMOVE, 32'hFFFF_FFFF);

    // Random part: runs of add-heavy, remove-heavy and mixed traffic over a key pool.
    bias = 0;
    for (int n = 0; n < 800; n++) begin
      if (n % 40 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = ACT_SPARE;
      end else if (bias == 0) begin
        act = (roll < 65) ? ACT_ADD : (roll < 82) ? ACT_REMOVE : ACT_QUERY;
      end else if (bias == 1) begin
        act = (roll < 20) ? ACT_ADD : (roll < 80) ? ACT_REMOVE : ACT_QUERY;
      end else begin
        act = (roll < 40) ? ACT_ADD : (roll < 70) ? ACT_REMOVE : ACT_QUERY;
      end
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N - 1)] : $urandom;
      push_cmd(act, k, (n == 400));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_bus.valid) @(posedge clk);
    while (accepted_cnt != results_seen) @(posedge clk);
    repeat (40) @(posedge clk);

    if (set_reply_q.size() != 0) begin
      $error("%0d expected replies never arrived", set_reply_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("bounded_unique_set_tb: done, clean");
    end else begin
      $display("bounded_unique_set_tb: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("bounded_unique_set_tb: done, errors");
    $finish;
  end

endmodule

FILE: bounded_unique_set.f
rtl/bus_pkg.sv
rtl/bus_in_if.sv
rtl/bus_out_if.sv
rtl/bus_store.sv
rtl/bounded_unique_set.sv
tb/sv/bounded_unique_set_tb.sv
